### src/teq_pkg.sv
// Package for the timer expiry queue: command and status codes, word and
// cell entry types shared by the cell chain, controller and checker.
// No dependencies.
package teq_pkg;

    localparam int ID_W   = 5;
    localparam int TIME_W = 32;

    typedef enum logic [1:0] {
        CMD_ARM    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERROR = 2'd1,
        ST_NONE  = 2'd2
    } t_status_code;

    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_EXPIRE = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_chain_op;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] expiry;
        logic [TIME_W-1:0] now;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic              expired_valid;
        logic [ID_W-1:0]   expired_id;
        logic              has_timer;
        logic [TIME_W-1:0] delta;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        t_chain_op         op;
        logic [ID_W-1:0]   key_id;
        logic [TIME_W-1:0] key_exp;
    } t_chain_cmd;

endpackage

### src/teq_cell.sv
// One cell of the sorted timer chain: holds a single timer entry and
// shifts towards its neighbours on insert and remove. Depends on teq_pkg.
module teq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  teq_pkg::t_chain_cmd i_cmd,
    input  teq_pkg::t_entry     i_left,
    input  logic                i_left_after,
    input  teq_pkg::t_entry     i_right,
    input  logic                i_rm_in,
    output teq_pkg::t_entry     o_entry,
    output logic                o_after,
    output logic                o_rm_out
);
    import teq_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_exp;
    t_entry            n_entry;
    logic              match;

    // Entry sorts after the key when empty or strictly later, so equal
    // expiries keep arming order.
    assign o_after  = !r_valid || (r_exp > i_cmd.key_exp);
    assign match    = r_valid && (r_id == i_cmd.key_id);
    assign o_rm_out = i_rm_in || match;
    assign o_entry  = '{valid: r_valid, id: r_id, expiry: r_exp};

    always_comb begin
        n_entry = o_entry;
        case (i_cmd.op)
            OP_INSERT: begin
                if (o_after && !i_left_after) begin
                    n_entry = '{valid: 1'b1, id: i_cmd.key_id, expiry: i_cmd.key_exp};
                end else if (o_after) begin
                    n_entry = i_left;
                end
            end
            OP_REMOVE: begin
                if (o_rm_out) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_entry.id;
        r_exp <= n_entry.expiry;
    end

endmodule

### src/teq_ctrl.sv
// Controller for the timer expiry queue: command decode, expire sequencer
// and output register. Drives the broadcast command of the cell chain.
// Depends on teq_pkg.
module teq_ctrl #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  teq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output teq_pkg::t_out_word  o_out_word,
    input  teq_pkg::t_entry     i_head,
    input  teq_pkg::t_entry     i_second,
    input  logic                i_hit,
    input  logic                i_full,
    output teq_pkg::t_chain_cmd o_chain
);
    import teq_pkg::*;

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;
    logic [TIME_W-1:0] r_now;
    logic              out_free;
    logic              accept;
    logic              fire;
    logic              next_fire;
    logic              in_range;
    logic              overdue;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign accept     = (r_state == S_IDLE) && i_in_valid && out_free;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign fire       = i_head.valid && (i_head.expiry <= r_now);
    assign next_fire  = i_second.valid && (i_second.expiry <= r_now);
    assign in_range   = 32'(i_in_word.timer_id) < TIMER_SLOTS;
    assign overdue    = i_head.expiry < i_in_word.now;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in_word.cmd == CMD_EXPIRE)) begin
                    n_state = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (out_free && (!fire || !next_fire)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid     = r_out_valid && i_out_stall;
        n_out           = r_out;
        o_chain.op      = OP_HOLD;
        o_chain.key_id  = i_in_word.timer_id;
        o_chain.key_exp = i_in_word.expiry;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out      = '0;
                    n_out.last = 1'b1;
                    case (i_in_word.cmd)
                        CMD_ARM: begin
                            n_out_valid = 1'b1;
                            if (!in_range || i_hit || i_full) begin
                                n_out.status = ST_ERROR;
                            end else begin
                                n_out.status = ST_OK;
                                o_chain.op   = OP_INSERT;
                            end
                        end
                        CMD_CANCEL: begin
                            n_out_valid = 1'b1;
                            if (!i_hit) begin
                                n_out.status = ST_ERROR;
                            end else begin
                                n_out.status = ST_OK;
                                o_chain.op   = OP_REMOVE;
                            end
                        end
                        CMD_QUERY: begin
                            n_out_valid     = 1'b1;
                            n_out.status    = ST_OK;
                            n_out.has_timer = i_head.valid;
                            if (i_head.valid && !overdue) begin
                                n_out.delta = i_head.expiry - i_in_word.now;
                            end
                        end
                        default: begin
                            // expire: results follow from the sequencer
                            n_out = r_out;
                        end
                    endcase
                end
            end
            S_EXPIRE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (fire) begin
                        // pop the head: remove by its own id
                        o_chain.op          = OP_REMOVE;
                        o_chain.key_id      = i_head.id;
                        n_out.status        = ST_OK;
                        n_out.expired_valid = 1'b1;
                        n_out.expired_id    = i_head.id;
                        n_out.last          = !next_fire;
                    end else begin
                        n_out.status = ST_NONE;
                        n_out.last   = 1'b1;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_now <= i_in_word.now;
        end
    end

endmodule

### src/timer_expiry_queue_core.sv
// Timer expiry queue: a chain of TIMER_SLOTS cells kept sorted by expiry.
// Arm, cancel and query give their word in the cycle after acceptance.
// Expire is accepted first, then gives one word per cycle, while the output
// is not stalled, for each fired timer (or one "nothing expired" word); input
// is held meanwhile. One arm, cancel or query per cycle while not stalled.
// Reset (synchronous, active low) empties every cell and idles the controller.
module timer_expiry_queue_core #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  teq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output teq_pkg::t_out_word o_out_word
);
    import teq_pkg::*;

    t_chain_cmd chain_cmd;
    t_entry     entries [TIMER_SLOTS];
    logic       after   [TIMER_SLOTS];
    logic       rm      [TIMER_SLOTS];

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_after;
        logic   rm_in;

        if (g == 0) begin : g_first
            assign left_e     = '0;
            assign left_after = 1'b0;
            assign rm_in      = 1'b0;
        end else begin : g_inner
            assign left_e     = entries[g-1];
            assign left_after = after[g-1];
            assign rm_in      = rm[g-1];
        end

        if (g == TIMER_SLOTS - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_mid
            assign right_e = entries[g+1];
        end

        teq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (chain_cmd),
            .i_left       (left_e),
            .i_left_after (left_after),
            .i_right      (right_e),
            .i_rm_in      (rm_in),
            .o_entry      (entries[g]),
            .o_after      (after[g]),
            .o_rm_out     (rm[g])
        );
    end

    teq_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_head      (entries[0]),
        .i_second    (entries[1]),
        .i_hit       (rm[TIMER_SLOTS-1]),
        .i_full      (entries[TIMER_SLOTS-1].valid),
        .o_chain     (chain_cmd)
    );

endmodule

### src/teq_checker.sv
// Port checker for timer_expiry_queue_core, attached by the bind below.
// Depends on teq_pkg.
module teq_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input teq_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input teq_pkg::t_out_word o_out_word
);
    import teq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_word.cmd != CMD_EXPIRE))
        |=> (o_out_valid && o_out_word.last))
        else $error("single-word command gave no final word");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last) |-> o_in_stall)
        else $error("input taken during an expire run");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_NONE))
        |-> (o_out_word.last && !o_out_word.expired_valid))
        else $error("nothing-expired word malformed");

endmodule

bind timer_expiry_queue_core teq_port_checker u_teq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### bench/teq_checker.sv
// Checker for the timer expiry queue: watches both word channels, keeps its
// own sorted timer store to predict each reply and compares it field by field.
// Depends on teq_pkg.
module teq_checker #(
    parameter int SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  teq_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  teq_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_cmd_count,
    output int                 o_reply_count,
    output int                 o_fired_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int ID_SPACE = 1 << ID_W;

    logic              timer_on  [ID_SPACE];
    logic [ID_W-1:0]   order_id  [SLOTS];
    logic [TIME_W-1:0] order_exp [SLOTS];
    int                live;
    t_out_word         reply_queue [$];

    function automatic t_out_word reply(input t_status_code st, input logic fired,
                                        input logic [ID_W-1:0] fid, input logic has,
                                        input logic [TIME_W-1:0] left, input logic lst);
        t_out_word r;
        r.status        = st;
        r.expired_valid = fired;
        r.expired_id    = fid;
        r.has_timer     = has;
        r.delta         = left;
        r.last          = lst;
        return r;
    endfunction

    // Close the gap left by the entry at pos.
    task automatic drop_slot(input int pos);
        int k;
        for (k = pos; k + 1 < live; k++) begin
            order_id[k]  = order_id[k + 1];
            order_exp[k] = order_exp[k + 1];
        end
        live--;
    endtask

    task automatic apply_command(input t_in_word w);
        int                pos;
        int                k;
        int                fired;
        logic [ID_W-1:0]   fid;
        logic [TIME_W-1:0] head;
        fired = 0;
        case (t_cmd_code'(w.cmd))
            CMD_ARM: begin
                if (w.timer_id >= SLOTS || timer_on[w.timer_id] || live >= SLOTS) begin
                    reply_queue.push_back(reply(ST_ERROR, 1'b0, '0, 1'b0, '0, 1'b1));
                end else begin
                    // Equal expiries stay in arming order: insert after them.
                    pos = 0;
                    while (pos < live && order_exp[pos] <= w.expiry)
                        pos++;
                    for (k = live; k > pos; k--) begin
                        order_id[k]  = order_id[k - 1];
                        order_exp[k] = order_exp[k - 1];
                    end
                    order_id[pos]        = w.timer_id;
                    order_exp[pos]       = w.expiry;
                    live++;
                    timer_on[w.timer_id] = 1'b1;
                    reply_queue.push_back(reply(ST_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                end
            end
            CMD_CANCEL: begin
                if (w.timer_id >= SLOTS || !timer_on[w.timer_id]) begin
                    reply_queue.push_back(reply(ST_ERROR, 1'b0, '0, 1'b0, '0, 1'b1));
                end else begin
                    for (pos = 0; pos < live; pos++) begin
                        if (order_id[pos] == w.timer_id) begin
                            drop_slot(pos);
                            break;
                        end
                    end
                    timer_on[w.timer_id] = 1'b0;
                    reply_queue.push_back(reply(ST_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                end
            end
            CMD_EXPIRE: begin
                while (live > 0 && order_exp[0] <= w.now) begin
                    fid           = order_id[0];
                    timer_on[fid] = 1'b0;
                    drop_slot(0);
                    reply_queue.push_back(reply(ST_OK, 1'b1, fid, 1'b0, '0, 1'b0));
                    fired++;
                end
                if (fired == 0)
                    reply_queue.push_back(reply(ST_NONE, 1'b0, '0, 1'b0, '0, 1'b1));
                else
                    reply_queue[reply_queue.size() - 1].last = 1'b1;
                o_fired_count += fired;
            end
            default: begin
                if (live == 0) begin
                    reply_queue.push_back(reply(ST_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                end else begin
                    head = order_exp[0];
                    reply_queue.push_back(reply(ST_OK, 1'b0, '0, 1'b1,
                                                (head >= w.now) ? head - w.now : '0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int k = 0; k < ID_SPACE; k++)
                timer_on[k] = 1'b0;
            live = 0;
            reply_queue.delete();
            o_fail_count  = 0;
            o_cmd_count   = 0;
            o_reply_count = 0;
            o_fired_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_in_word);
                o_cmd_count++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_reply_count++;
                if (reply_queue.size() == 0) begin
                    $display("%0t: unexpected reply word, expected none, got %h",
                             $time, i_out_word);
                    o_fail_count++;
                end else begin
                    want = reply_queue.pop_front();
                    check_field("status", TIME_W'(want.status),
                                TIME_W'(i_out_word.status));
                    check_field("expired_valid", TIME_W'(want.expired_valid),
                                TIME_W'(i_out_word.expired_valid));
                    check_field("expired_id", TIME_W'(want.expired_id),
                                TIME_W'(i_out_word.expired_id));
                    check_field("has_timer", TIME_W'(want.has_timer),
                                TIME_W'(i_out_word.has_timer));
                    check_field("delta", want.delta, i_out_word.delta);
                    check_field("last", TIME_W'(want.last), TIME_W'(i_out_word.last));
                end
            end
        end
        o_pending = reply_queue.size();
    end

endmodule

### bench/timer_expiry_queue_core_test.sv
// Top of the timer expiry queue bench: clock, reset, command stimulus with
// idling phases and an output hold-off, and the final verdict.
// Depends on teq_pkg, timer_expiry_queue_core and teq_checker.
module timer_expiry_queue_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int SLOTS       = 32;
    localparam int RANDOM_CMDS = 230;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;

    int          fail_count;
    int          pending;
    int          cmd_count;
    int          reply_count;
    int          fired_count;

    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          sent_count = 0;
    int          cycles     = 0;
    logic [31:0] clock_ms   = '0;
    logic [4:0]  last_armed = '0;

    timer_expiry_queue_core #(.TIMER_SLOTS(SLOTS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    teq_checker #(.SLOTS(SLOTS)) watch (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_cmd_count   (cmd_count),
        .o_reply_count (reply_count),
        .o_fired_count (fired_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d replies outstanding",
                     $time, cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in_word cmd_word(input t_cmd_code c, input logic [4:0] id,
                                          input logic [31:0] exp, input logic [31:0] at);
        t_in_word w;
        w.cmd      = c;
        w.timer_id = id;
        w.expiry   = exp;
        w.now      = at;
        return w;
    endfunction

    // Mostly well-formed traffic around a moving time base; unused fields carry junk.
    function automatic t_in_word random_command();
        t_in_word w;
        int       pick;
        w.timer_id = ID_W'($urandom);
        w.expiry   = $urandom;
        w.now      = $urandom;
        pick       = $urandom_range(0, 99);
        if (pick < 40) begin
            w.cmd = CMD_ARM;
            if ($urandom_range(0, 9) != 0)
                w.expiry = clock_ms + $urandom_range(0, 300);
            last_armed = w.timer_id;
        end else if (pick < 60) begin
            w.cmd = CMD_CANCEL;
            if ($urandom_range(0, 1) == 0)
                w.timer_id = last_armed;
        end else if (pick < 80) begin
            w.cmd    = CMD_EXPIRE;
            clock_ms = clock_ms + $urandom_range(0, 120);
            if ($urandom_range(0, 19) != 0)
                w.now = clock_ms;
        end else begin
            w.cmd = CMD_QUERY;
            if ($urandom_range(0, 9) != 0)
                w.now = clock_ms + $urandom_range(0, 60) - 20;
        end
        return w;
    endfunction

    task automatic send_command(input t_in_word w);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // Flush, arm every id in a shuffled order, then try one more against a full store.
    task automatic fill_store();
        int k;
        int offset;
        offset = $urandom_range(0, SLOTS - 1);
        send_command(cmd_word(CMD_EXPIRE, ID_W'($urandom), $urandom, 32'hFFFF_FFFF));
        for (k = 0; k < SLOTS; k++)
            send_command(cmd_word(CMD_ARM, ID_W'((k * 7 + offset) % SLOTS),
                                  clock_ms + $urandom_range(0, 400), $urandom));
        send_command(cmd_word(CMD_ARM, ID_W'($urandom), $urandom, $urandom));
    endtask

    // Receiver: random stalls per phase, plus one long hold-off to back the block up.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && sent_count >= 40) begin
                hold_left = 90;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        int done;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(cmd_word(CMD_QUERY, 5'd0, 32'd0, 32'd0));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'hFFFF_FFFF));
        send_command(cmd_word(CMD_CANCEL, 5'd0, 32'd0, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd0, 32'd0, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd0, 32'd5, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_command(cmd_word(CMD_ARM, 5'd10, 32'd1000, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd11, 32'd1000, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd12, 32'd500, 32'd0));
        send_command(cmd_word(CMD_QUERY, 5'd0, 32'd0, 32'd0));
        send_command(cmd_word(CMD_QUERY, 5'd31, 32'd0, 32'hFFFF_FFFF));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'd0));
        send_command(cmd_word(CMD_QUERY, 5'd0, 32'd0, 32'd100));
        send_command(cmd_word(CMD_CANCEL, 5'd12, 32'd0, 32'd0));
        send_command(cmd_word(CMD_CANCEL, 5'd12, 32'd0, 32'd0));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'd999));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'd1000));
        send_command(cmd_word(CMD_ARM, 5'd20, 32'd1000, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd21, 32'd1000, 32'd0));
        send_command(cmd_word(CMD_ARM, 5'd22, 32'd999, 32'd0));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'hFFFF_FFFE));
        send_command(cmd_word(CMD_EXPIRE, 5'd0, 32'd0, 32'hFFFF_FFFF));
        send_command(cmd_word(CMD_QUERY, 5'd0, 32'd0, 32'hFFFF_FFFF));

        clock_ms = $urandom;
        done     = 0;
        while (done < RANDOM_CMDS) begin
            case ((done / 46) % 5)
                1:       begin gap_pct = 55; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 55; end
                3:       begin gap_pct = 25; stall_pct = 25; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            if (done == 50 || done == 140) begin
                fill_store();
                done += SLOTS + 2;
            end else begin
                send_command(random_command());
                done++;
            end
        end
        in_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (40) @(posedge clk);

        $display("Run covered %0d commands and %0d reply words, %0d of them timer firings,",
                 cmd_count, reply_count, fired_count);
        $display("across idle, sender-gap, receiver-stall and mixed phases with one long hold-off.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
